// ----- hw/rtl/bqsp_pkg.sv -----
package bqsp_pkg;

    localparam int DEF_MAX_SEGMENTS = 1024;
    localparam int DEF_MAX_EDGES    = 4096;
    localparam int NUM_BUCKETS      = 512;
    localparam int BKT_W            = 9;
    localparam int STEP_SCALE       = 2 * (NUM_BUCKETS - 1);

    localparam int CMD_W      = 3;
    localparam int IDX_W      = 10;
    localparam int LEN_W      = 24;
    localparam int DIST_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_W      = 11;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 40;
    localparam int NUM_W      = 34;
    localparam int DEN_W      = LEN_W + 1;
    localparam int K_W        = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_LENGTH = 3'd0,
        CMD_APPEND     = 3'd1,
        CMD_MARK       = 3'd2,
        CMD_RUN        = 3'd3,
        CMD_READ       = 3'd4,
        CMD_CLEAR      = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        OP_CLR,
        OP_IDLE,
        OP_DECODE,
        OP_APP_RD,
        OP_APP_WR,
        OP_READ_RD,
        OP_READ_OUT,
        OP_INIT_SEG,
        OP_INIT_BKT,
        OP_ORIG_RD,
        OP_ORIG_CHK,
        OP_DIV,
        OP_PUSH_RD,
        OP_PUSH_WR,
        OP_LOOP,
        OP_SCAN_RD,
        OP_SCAN_CHK,
        OP_POP_RD,
        OP_POP_WR,
        OP_SEG_RD,
        OP_SEG_CHK,
        OP_EDGE_RD,
        OP_EDGE_T,
        OP_EDGE_CHK,
        OP_RESP
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_CLR,
        ST_IDLE,
        ST_DECODE,
        ST_APP_RD,
        ST_APP_WR,
        ST_READ_RD,
        ST_READ_OUT,
        ST_INIT_SEG,
        ST_INIT_BKT,
        ST_ORIG_RD,
        ST_ORIG_CHK,
        ST_DIV,
        ST_PUSH_RD,
        ST_PUSH_WR,
        ST_LOOP,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_POP_RD,
        ST_POP_WR,
        ST_SEG_RD,
        ST_SEG_CHK,
        ST_EDGE_RD,
        ST_EDGE_T,
        ST_EDGE_CHK,
        ST_RESP
    } ctrl_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_MUL,
        DIV_ADD,
        DIV_ITER
    } div_phase_t;

    typedef struct packed {
        cmd_t cmd;
        logic cmd_ok;
        logic i_lt_n;
        logic i_lt_bkt;
        logic i_lt_max;
        logic origin_hit;
        logic div_done;
        logic open_zero;
        logic bucket_empty;
        logic seg_done;
        logic e_lt_stop;
        logic t_in_range;
        logic seen_pass;
        logic out_free;
    } dp_stat_t;

    function automatic logic [DIST_W-1:0] sat_add(logic [DIST_W-1:0] a, logic [LEN_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + (DIST_W+1)'(b);
        return s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] half_len(logic [LEN_W-1:0] len);
        logic [LEN_W:0] h;
        h = ({1'b0, len} + (LEN_W+1)'(1)) >> 1;
        return h[LEN_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/bqsp_step_div.sv -----
module bqsp_step_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [bqsp_pkg::LEN_W-1:0] len,
    input  logic [bqsp_pkg::LEN_W-1:0] max_len,
    output logic                    done,
    output logic [bqsp_pkg::BKT_W-1:0] step
);
    import bqsp_pkg::*;

    div_phase_t            phase_reg, phase_next;
    logic                  done_reg;
    logic [NUM_W-1:0]      prod_reg;
    logic [NUM_W-1:0]      rem_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [LEN_W-1:0]      max_reg;
    logic                  max0_reg;
    logic [BKT_W-1:0]      q_reg;
    logic [K_W-1:0]        k_reg;
    logic [NUM_W-1:0]      trial;
    logic                  fits;

    assign trial = NUM_W'(den_reg) << k_reg;
    assign fits  = rem_reg >= trial;

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            DIV_IDLE: phase_next = start ? DIV_MUL : DIV_IDLE;
            DIV_MUL:  phase_next = DIV_ADD;
            DIV_ADD:  phase_next = DIV_ITER;
            DIV_ITER: phase_next = (k_reg == '0) ? DIV_IDLE : DIV_ITER;
            default:  phase_next = DIV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (start)
                done_reg <= 1'b0;
            else if (phase_reg == DIV_ITER && k_reg == '0)
                done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (phase_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    prod_reg <= NUM_W'(len) * NUM_W'(STEP_SCALE);
                    den_reg  <= {max_len, 1'b0};
                    max_reg  <= max_len;
                    max0_reg <= (max_len == '0);
                end
            end
            DIV_MUL:
            begin
                rem_reg <= prod_reg + NUM_W'(max_reg);
                k_reg   <= K_W'(BKT_W - 1);
                q_reg   <= '0;
            end
            DIV_ADD:
            begin
                k_reg <= K_W'(BKT_W - 1);
            end
            DIV_ITER:
            begin
                if (fits)
                    rem_reg <= rem_reg - trial;
                q_reg[k_reg] <= fits;
                k_reg <= k_reg - K_W'(1);
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign step = max0_reg ? '0 : q_reg;

endmodule

// ----- hw/rtl/bqsp_datapath.sv -----
module bqsp_datapath #(
    parameter int MAX_SEGMENTS = bqsp_pkg::DEF_MAX_SEGMENTS,
    parameter int MAX_EDGES    = bqsp_pkg::DEF_MAX_EDGES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bqsp_pkg::dp_op_t              op,
    output bqsp_pkg::dp_stat_t            stat,
    input  logic                          in_accept,
    input  logic [bqsp_pkg::CMD_W-1:0]    in_cmd,
    input  logic [bqsp_pkg::IDX_W-1:0]    in_seg,
    input  logic [bqsp_pkg::IDX_W-1:0]    in_nbr,
    input  logic [bqsp_pkg::LEN_W-1:0]    in_len,
    input  logic                          cfg_we,
    input  logic [bqsp_pkg::CFG_W-1:0]    cfg_wdata,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bqsp_pkg::STATUS_W-1:0] out_status,
    output logic                          out_run_done,
    output logic                          out_reached,
    output logic [bqsp_pkg::DIST_W-1:0]   out_distance
);
    import bqsp_pkg::*;

    localparam int SEG_W     = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SEGMENTS + 1);
    localparam int EDGE_W    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int FILL_W    = $clog2(MAX_EDGES + 1);
    localparam int POOL      = MAX_SEGMENTS + MAX_EDGES;
    localparam int POOL_W    = $clog2(POOL);
    localparam int BUMP_W    = $clog2(POOL + 1);
    localparam int SWEEP_MAX = (MAX_SEGMENTS > NUM_BUCKETS) ? MAX_SEGMENTS : NUM_BUCKETS;
    localparam int I_W       = $clog2(SWEEP_MAX + 1);

    logic [LEN_W-1:0]  len_mem  [MAX_SEGMENTS];
    logic [FILL_W-1:0] beg_mem  [MAX_SEGMENTS];
    logic [FILL_W-1:0] end_mem  [MAX_SEGMENTS];
    logic [SEG_W-1:0]  tgt_mem  [MAX_EDGES];
    logic              org_mem  [MAX_SEGMENTS];
    logic [DIST_W-1:0] seen_mem [MAX_SEGMENTS];
    logic [DIST_W-1:0] path_mem [MAX_SEGMENTS];
    logic              done_mem [MAX_SEGMENTS];
    logic [DIST_W-1:0] res_mem  [MAX_SEGMENTS];
    logic              rch_mem  [MAX_SEGMENTS];
    logic [POOL_W:0]   head_mem [NUM_BUCKETS];
    logic [SEG_W-1:0]  pseg_mem [POOL];
    logic [POOL_W:0]   pnext_mem[POOL];
    logic [POOL_W-1:0] free_mem [POOL];

    logic [LEN_W-1:0]  len_rd;
    logic [FILL_W-1:0] beg_rd, end_rd;
    logic [SEG_W-1:0]  tgt_rd;
    logic              org_rd;
    logic [DIST_W-1:0] seen_rd, path_rd, res_rd;
    logic              done_rd, rch_rd;
    logic [POOL_W:0]   head_rd, pnext_rd;
    logic [SEG_W-1:0]  pseg_rd;
    logic [POOL_W-1:0] free_rd;

    logic [CFG_W-1:0]    count_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [IDX_W-1:0]    s_reg, t_in_reg;
    logic [LEN_W-1:0]    l_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [I_W-1:0]      i_reg;
    logic [LEN_W-1:0]    max_reg;
    logic                max_upd_reg;
    logic [BUMP_W-1:0]   open_reg, bump_reg, sp_reg;
    logic [BKT_W-1:0]    cur_reg;
    logic [DIST_W-1:0]   depth_reg;
    logic                ok_reg;
    logic [SEG_W-1:0]    seg_reg, t_reg, push_seg_reg;
    logic [POOL_W-1:0]   pop_e_reg;
    logic [FILL_W-1:0]   e_reg, stop_reg;
    logic [DIST_W-1:0]   pd_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                res_done_reg, res_reached_reg;
    logic [DIST_W-1:0]   res_dist_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_done_reg, out_reached_reg;
    logic [DIST_W-1:0]   out_dist_reg;

    logic [CNT_W-1:0]  n_eff;
    logic              s_ok, t_ok, range_err, full_err;
    logic [STATUS_W-1:0] dec_status;
    logic [SEG_W-1:0]  s_addr, i_seg;
    logic              div_start, div_done;
    logic [BKT_W-1:0]  div_step, push_bkt;
    logic              pool_full;
    logic [POOL_W-1:0] alloc_e;
    logic              out_free;
    logic              org_pass, seen_pass;

    logic              len_we;   logic [SEG_W-1:0] len_ra;
    logic              be_we;    logic [SEG_W-1:0] be_wa, be_ra;
    logic [FILL_W-1:0] beg_wd, end_wd;
    logic              tgt_we;
    logic              org_we, org_wd;
    logic              seen_we;  logic [SEG_W-1:0] seen_wa, seen_ra;
    logic [DIST_W-1:0] seen_wd;
    logic              path_we;  logic [SEG_W-1:0] path_wa;
    logic [DIST_W-1:0] path_wd;
    logic              res_we;   logic [SEG_W-1:0] res_wa;
    logic [DIST_W-1:0] res_wd;
    logic              rch_we, rch_wd; logic [SEG_W-1:0] rch_wa;
    logic              done_we, done_wd; logic [SEG_W-1:0] done_wa;
    logic              org_wsel;
    logic              head_we;  logic [BKT_W-1:0] head_wa, head_ra;
    logic [POOL_W:0]   head_wd;
    logic              pool_we;

    assign n_eff = (32'(count_reg) > 32'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS)
                                                        : CNT_W'(count_reg);
    assign s_ok     = 32'(s_reg) < 32'(n_eff);
    assign t_ok     = 32'(t_in_reg) < 32'(n_eff);
    assign s_addr   = SEG_W'(s_reg);
    assign i_seg    = i_reg[SEG_W-1:0];
    assign push_bkt = cur_reg + div_step;
    assign pool_full = open_reg == BUMP_W'(POOL);
    assign alloc_e  = (bump_reg < BUMP_W'(POOL)) ? bump_reg[POOL_W-1:0] : free_rd;
    assign out_free = !out_valid_reg || out_ready;
    assign org_pass = (op == OP_ORIG_CHK) && org_rd;
    assign seen_pass = seen_rd > depth_reg;
    assign div_start = org_pass || ((op == OP_EDGE_CHK) && seen_pass);

    always_comb
    begin
        range_err = 1'b0;
        full_err  = 1'b0;
        case (cmd_t'(cmd_reg))
            CMD_SET_LENGTH, CMD_MARK, CMD_READ: range_err = !s_ok;
            CMD_APPEND:
            begin
                range_err = !s_ok || !t_ok;
                full_err  = 32'(fill_reg) >= 32'(MAX_EDGES);
            end
            default: range_err = 1'b0;
        endcase
        if (range_err)
            dec_status = STAT_RANGE;
        else if (full_err)
            dec_status = STAT_FULL;
        else
            dec_status = STAT_OK;
    end

    always_comb
    begin
        stat.cmd          = cmd_t'(cmd_reg);
        stat.cmd_ok       = dec_status == STAT_OK;
        stat.i_lt_n       = 32'(i_reg) < 32'(n_eff);
        stat.i_lt_bkt     = 32'(i_reg) < 32'(NUM_BUCKETS);
        stat.i_lt_max     = 32'(i_reg) < 32'(MAX_SEGMENTS);
        stat.origin_hit   = org_rd;
        stat.div_done     = div_done;
        stat.open_zero    = open_reg == '0;
        stat.bucket_empty = !head_rd[POOL_W];
        stat.seg_done     = done_rd;
        stat.e_lt_stop    = e_reg < stop_reg;
        stat.t_in_range   = 32'(tgt_rd) < 32'(n_eff);
        stat.seen_pass    = seen_pass;
        stat.out_free     = out_free;
    end

    // memory port selection
    always_comb
    begin
        len_we  = (op == OP_DECODE) && (cmd_t'(cmd_reg) == CMD_SET_LENGTH) && s_ok;
        len_ra  = (op == OP_EDGE_T) ? tgt_rd : i_seg;

        be_we   = ((op == OP_CLR) && stat.i_lt_max) || (op == OP_APP_WR);
        be_wa   = (op == OP_CLR) ? i_seg : s_addr;
        be_ra   = (op == OP_SEG_RD) ? seg_reg : s_addr;
        beg_wd  = '0;
        end_wd  = '0;
        if (op == OP_APP_WR)
        begin
            beg_wd = (beg_rd == end_rd) ? fill_reg : beg_rd;
            end_wd = fill_reg + FILL_W'(1);
        end
        tgt_we  = op == OP_APP_WR;

        org_wsel = (op == OP_CLR) && stat.i_lt_max;
        org_we   = org_wsel || ((op == OP_DECODE) && (cmd_t'(cmd_reg) == CMD_MARK) && s_ok);
        org_wd   = !org_wsel;

        seen_we = ((op == OP_INIT_SEG) && stat.i_lt_n) || org_pass
                  || ((op == OP_EDGE_CHK) && seen_pass);
        seen_wa = (op == OP_EDGE_CHK) ? t_reg : i_seg;
        seen_wd = (op == OP_INIT_SEG) ? {DIST_W{1'b1}} : (op == OP_EDGE_CHK) ? depth_reg : '0;
        seen_ra = tgt_rd;

        path_we = org_pass || ((op == OP_EDGE_CHK) && seen_pass);
        path_wa = (op == OP_EDGE_CHK) ? t_reg : i_seg;
        path_wd = (op == OP_EDGE_CHK) ? sat_add(pd_reg, len_rd) : DIST_W'(half_len(len_rd));

        res_we  = path_we;
        res_wa  = path_wa;
        res_wd  = (op == OP_EDGE_CHK) ? sat_add(pd_reg, half_len(len_rd)) : '0;

        rch_we  = ((op == OP_CLR) && stat.i_lt_max) || ((op == OP_INIT_SEG) && stat.i_lt_n)
                  || path_we;
        rch_wa  = path_wa;
        rch_wd  = path_we;

        done_we = ((op == OP_INIT_SEG) && stat.i_lt_n) || ((op == OP_SEG_CHK) && !done_rd);
        done_wa = (op == OP_SEG_CHK) ? seg_reg : i_seg;
        done_wd = op == OP_SEG_CHK;

        head_we = ((op == OP_INIT_BKT) && stat.i_lt_bkt) || (op == OP_POP_WR)
                  || ((op == OP_PUSH_WR) && !pool_full);
        head_wa = (op == OP_PUSH_WR) ? push_bkt
                : (op == OP_POP_WR) ? cur_reg : i_reg[BKT_W-1:0];
        head_wd = (op == OP_PUSH_WR) ? {1'b1, alloc_e}
                : (op == OP_POP_WR) ? pnext_rd : '0;
        head_ra = (op == OP_PUSH_RD) ? push_bkt : cur_reg;

        pool_we = (op == OP_PUSH_WR) && !pool_full;
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
            len_mem[s_addr] <= l_reg;
        len_rd <= len_mem[len_ra];
    end

    always_ff @(posedge clk)
    begin
        if (be_we)
        begin
            beg_mem[be_wa] <= beg_wd;
            end_mem[be_wa] <= end_wd;
        end
        beg_rd <= beg_mem[be_ra];
        end_rd <= end_mem[be_ra];
    end

    always_ff @(posedge clk)
    begin
        if (tgt_we)
            tgt_mem[fill_reg[EDGE_W-1:0]] <= SEG_W'(t_in_reg);
        tgt_rd <= tgt_mem[e_reg[EDGE_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (org_we)
            org_mem[org_wsel ? i_seg : s_addr] <= org_wd;
        org_rd <= org_mem[i_seg];
    end

    always_ff @(posedge clk)
    begin
        if (seen_we)
            seen_mem[seen_wa] <= seen_wd;
        seen_rd <= seen_mem[seen_ra];
    end

    always_ff @(posedge clk)
    begin
        if (path_we)
            path_mem[path_wa] <= path_wd;
        path_rd <= path_mem[seg_reg];
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
            res_mem[res_wa] <= res_wd;
        res_rd <= res_mem[s_addr];
    end

    always_ff @(posedge clk)
    begin
        if (rch_we)
            rch_mem[rch_wa] <= rch_wd;
        rch_rd <= rch_mem[s_addr];
    end

    always_ff @(posedge clk)
    begin
        if (done_we)
            done_mem[done_wa] <= done_wd;
        done_rd <= done_mem[seg_reg];
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_wa] <= head_wd;
        head_rd <= head_mem[head_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pool_we)
        begin
            pseg_mem[alloc_e]  <= push_seg_reg;
            pnext_mem[alloc_e] <= head_rd;
        end
        pseg_rd  <= pseg_mem[pop_e_reg];
        pnext_rd <= pnext_mem[pop_e_reg];
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_POP_WR)
            free_mem[sp_reg[POOL_W-1:0]] <= pop_e_reg;
        free_rd <= free_mem[sp_reg[POOL_W-1:0] - POOL_W'(1)];
    end

    bqsp_step_div u_step_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .len     (len_rd),
        .max_len (max_reg),
        .done    (div_done),
        .step    (div_step)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            fill_reg      <= '0;
            i_reg         <= '0;
            max_reg       <= '0;
            max_upd_reg   <= 1'b0;
            open_reg      <= '0;
            bump_reg      <= '0;
            sp_reg        <= '0;
            cur_reg       <= '0;
            depth_reg     <= '0;
            ok_reg        <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                count_reg <= cfg_wdata;

            max_upd_reg <= (op == OP_INIT_SEG) && stat.i_lt_n;
            if (max_upd_reg && (len_rd > max_reg))
                max_reg <= len_rd;

            case (op)
                OP_CLR:
                begin
                    fill_reg <= '0;
                    i_reg    <= stat.i_lt_max ? i_reg + I_W'(1) : '0;
                end
                OP_DECODE:
                begin
                    i_reg <= '0;
                    if (cmd_t'(cmd_reg) == CMD_RUN)
                    begin
                        max_reg   <= '0;
                        open_reg  <= '0;
                        bump_reg  <= '0;
                        sp_reg    <= '0;
                        cur_reg   <= '0;
                        depth_reg <= '0;
                        ok_reg    <= 1'b1;
                    end
                end
                OP_APP_WR:   fill_reg <= fill_reg + FILL_W'(1);
                OP_INIT_SEG: i_reg <= stat.i_lt_n ? i_reg + I_W'(1) : '0;
                OP_INIT_BKT: i_reg <= stat.i_lt_bkt ? i_reg + I_W'(1) : '0;
                OP_ORIG_CHK: i_reg <= i_reg + I_W'(1);
                OP_PUSH_WR:
                begin
                    if (pool_full)
                        ok_reg <= 1'b0;
                    else
                    begin
                        open_reg <= open_reg + BUMP_W'(1);
                        if (bump_reg < BUMP_W'(POOL))
                            bump_reg <= bump_reg + BUMP_W'(1);
                        else
                            sp_reg <= sp_reg - BUMP_W'(1);
                    end
                end
                OP_SCAN_CHK:
                begin
                    if (!head_rd[POOL_W])
                    begin
                        cur_reg   <= cur_reg + BKT_W'(1);
                        depth_reg <= depth_reg + DIST_W'(1);
                    end
                end
                OP_POP_WR:
                begin
                    sp_reg   <= sp_reg + BUMP_W'(1);
                    open_reg <= open_reg - BUMP_W'(1);
                end
                default: i_reg <= i_reg;
            endcase

            if ((op == OP_RESP) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg  <= in_cmd;
            s_reg    <= in_seg;
            t_in_reg <= in_nbr;
            l_reg    <= in_len;
        end
        case (op)
            OP_DECODE:
            begin
                res_status_reg  <= dec_status;
                res_done_reg    <= 1'b0;
                res_reached_reg <= 1'b0;
                res_dist_reg    <= '0;
            end
            OP_READ_OUT:
            begin
                res_reached_reg <= rch_rd;
                res_dist_reg    <= rch_rd ? res_rd : '0;
            end
            OP_LOOP:
            begin
                if (open_reg == '0)
                begin
                    res_status_reg <= ok_reg ? STAT_OK : STAT_FULL;
                    res_done_reg   <= 1'b1;
                end
            end
            OP_ORIG_CHK:  push_seg_reg <= i_seg;
            OP_SCAN_CHK:  pop_e_reg <= head_rd[POOL_W-1:0];
            OP_POP_WR:    seg_reg <= pseg_rd;
            OP_SEG_CHK:
            begin
                e_reg    <= beg_rd;
                stop_reg <= end_rd;
                pd_reg   <= path_rd;
            end
            OP_EDGE_T:
            begin
                t_reg <= tgt_rd;
                e_reg <= e_reg + FILL_W'(1);
            end
            OP_EDGE_CHK:  push_seg_reg <= t_reg;
            OP_RESP:
            begin
                if (out_free)
                begin
                    out_status_reg  <= res_status_reg;
                    out_done_reg    <= res_done_reg;
                    out_reached_reg <= res_reached_reg;
                    out_dist_reg    <= res_dist_reg;
                end
            end
            default: res_done_reg <= res_done_reg;
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_run_done = out_done_reg;
    assign out_reached  = out_reached_reg;
    assign out_distance = out_dist_reg;

    a_pool_balance: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg + sp_reg == bump_reg)
        else $error("pool entries in use do not match allocations");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= 32'(MAX_EDGES))
        else $error("edge fill beyond store");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_PUSH_WR) && !pool_full |=> open_reg == $past(open_reg) + BUMP_W'(1))
        else $error("push did not take a pool entry");

endmodule

// ----- hw/rtl/bqsp_ctrl.sv -----
module bqsp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bqsp_pkg::dp_stat_t stat,
    output bqsp_pkg::dp_op_t   op
);
    import bqsp_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        ret_orig_reg, ret_orig_next;
    logic        clr_resp_reg, clr_resp_next;

    always_comb
    begin
        state_next    = state_reg;
        ret_orig_next = ret_orig_reg;
        clr_resp_next = clr_resp_reg;
        case (state_reg)
            ST_CLR:      if (!stat.i_lt_max) state_next = clr_resp_reg ? ST_RESP : ST_IDLE;
            ST_IDLE:     if (in_valid) state_next = ST_DECODE;
            ST_DECODE:
            begin
                clr_resp_next = 1'b1;
                if (!stat.cmd_ok)
                    state_next = ST_RESP;
                else
                begin
                    case (stat.cmd)
                        CMD_APPEND: state_next = ST_APP_RD;
                        CMD_RUN:    state_next = ST_INIT_SEG;
                        CMD_READ:   state_next = ST_READ_RD;
                        CMD_CLEAR:  state_next = ST_CLR;
                        default:    state_next = ST_RESP;
                    endcase
                end
            end
            ST_APP_RD:   state_next = ST_APP_WR;
            ST_APP_WR:   state_next = ST_RESP;
            ST_READ_RD:  state_next = ST_READ_OUT;
            ST_READ_OUT: state_next = ST_RESP;
            ST_INIT_SEG: if (!stat.i_lt_n) state_next = ST_INIT_BKT;
            ST_INIT_BKT: if (!stat.i_lt_bkt) state_next = ST_ORIG_RD;
            ST_ORIG_RD:  state_next = stat.i_lt_n ? ST_ORIG_CHK : ST_LOOP;
            ST_ORIG_CHK:
            begin
                ret_orig_next = 1'b1;
                state_next = stat.origin_hit ? ST_DIV : ST_ORIG_RD;
            end
            ST_DIV:      if (stat.div_done) state_next = ST_PUSH_RD;
            ST_PUSH_RD:  state_next = ST_PUSH_WR;
            ST_PUSH_WR:  state_next = ret_orig_reg ? ST_ORIG_RD : ST_EDGE_RD;
            ST_LOOP:     state_next = stat.open_zero ? ST_RESP : ST_SCAN_RD;
            ST_SCAN_RD:  state_next = ST_SCAN_CHK;
            ST_SCAN_CHK: state_next = stat.bucket_empty ? ST_SCAN_RD : ST_POP_RD;
            ST_POP_RD:   state_next = ST_POP_WR;
            ST_POP_WR:   state_next = ST_SEG_RD;
            ST_SEG_RD:   state_next = ST_SEG_CHK;
            ST_SEG_CHK:  state_next = stat.seg_done ? ST_LOOP : ST_EDGE_RD;
            ST_EDGE_RD:  state_next = stat.e_lt_stop ? ST_EDGE_T : ST_LOOP;
            ST_EDGE_T:   state_next = stat.t_in_range ? ST_EDGE_CHK : ST_EDGE_RD;
            ST_EDGE_CHK:
            begin
                ret_orig_next = 1'b0;
                state_next = stat.seen_pass ? ST_DIV : ST_EDGE_RD;
            end
            ST_RESP:     if (stat.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        case (state_reg)
            ST_CLR:      op = OP_CLR;
            ST_IDLE:
            begin
                op = OP_IDLE;
                in_ready = 1'b1;
            end
            ST_DECODE:   op = OP_DECODE;
            ST_APP_RD:   op = OP_APP_RD;
            ST_APP_WR:   op = OP_APP_WR;
            ST_READ_RD:  op = OP_READ_RD;
            ST_READ_OUT: op = OP_READ_OUT;
            ST_INIT_SEG: op = OP_INIT_SEG;
            ST_INIT_BKT: op = OP_INIT_BKT;
            ST_ORIG_RD:  op = OP_ORIG_RD;
            ST_ORIG_CHK: op = OP_ORIG_CHK;
            ST_DIV:      op = OP_DIV;
            ST_PUSH_RD:  op = OP_PUSH_RD;
            ST_PUSH_WR:  op = OP_PUSH_WR;
            ST_LOOP:     op = OP_LOOP;
            ST_SCAN_RD:  op = OP_SCAN_RD;
            ST_SCAN_CHK: op = OP_SCAN_CHK;
            ST_POP_RD:   op = OP_POP_RD;
            ST_POP_WR:   op = OP_POP_WR;
            ST_SEG_RD:   op = OP_SEG_RD;
            ST_SEG_CHK:  op = OP_SEG_CHK;
            ST_EDGE_RD:  op = OP_EDGE_RD;
            ST_EDGE_T:   op = OP_EDGE_T;
            ST_EDGE_CHK: op = OP_EDGE_CHK;
            ST_RESP:     op = OP_RESP;
            default:     op = OP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLR;
            ret_orig_reg <= 1'b0;
            clr_resp_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_orig_reg <= ret_orig_next;
            clr_resp_reg <= clr_resp_next;
        end
    end

endmodule

// ----- hw/rtl/bucket_queue_metric_shortest_path.sv -----
// Metric shortest-path engine over a segment graph, walked with 512 circular LIFO buckets.
// One command is taken at a time and answered with exactly one result; the next command
// is taken while that result waits on the output. Set length, mark origin, range errors and
// unknown commands are answered from decode; append edge and read distance read their
// tables first. Clear graph sweeps the per-segment tables at one entry a cycle; the same
// sweep runs after reset (no command is taken during the reset pass, segment count writes
// are). A run first sets up the per-segment and bucket tables and pushes the marked
// origins, then advances buckets, pops segments, walks each popped segment not yet done
// and visits its edges, skipping targets past the count; every push waits on the
// bucket-step divider, which retires one quotient bit a cycle.
module bucket_queue_metric_shortest_path #(
    parameter int MAX_SEGMENTS = bqsp_pkg::DEF_MAX_SEGMENTS,
    parameter int MAX_EDGES    = bqsp_pkg::DEF_MAX_EDGES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bqsp_pkg::S_TDATA_W-1:0] s_axis_tdata,   // seg_index, neighbor_index, seg_length
    input  logic [bqsp_pkg::CMD_W-1:0]     s_axis_tuser,   // cmd
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bqsp_pkg::M_TDATA_W-1:0] m_axis_tdata,   // status, run_done, reached, distance
    input  logic                           cfg_we,
    input  logic [bqsp_pkg::CFG_W-1:0]     cfg_wdata
);
    import bqsp_pkg::*;

    dp_op_t              op;
    dp_stat_t            stat;
    logic                in_accept;
    logic [STATUS_W-1:0] status;
    logic                run_done;
    logic                reached;
    logic [DIST_W-1:0]   distance;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    bqsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .op       (op)
    );

    bqsp_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .MAX_EDGES    (MAX_EDGES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .stat         (stat),
        .in_accept    (in_accept),
        .in_cmd       (s_axis_tuser),
        .in_seg       (s_axis_tdata[IDX_W-1:0]),
        .in_nbr       (s_axis_tdata[2*IDX_W-1:IDX_W]),
        .in_len       (s_axis_tdata[2*IDX_W+LEN_W-1:2*IDX_W]),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_status   (status),
        .out_run_done (run_done),
        .out_reached  (reached),
        .out_distance (distance)
    );

    assign m_axis_tdata = {(M_TDATA_W - DIST_W - STATUS_W - 2)'(0), distance, reached,
                           run_done, status};

endmodule

// ----- tb/tb_bucket_queue_metric_shortest_path.sv -----
`timescale 1ns / 100ps

import bqsp_pkg::*;

typedef struct {
    logic [STATUS_W-1:0] status;
    logic                run_done;
    logic                reached;
    logic [DIST_W-1:0]   distance;
} path_result_t;

class path_scoreboard;
    localparam int unsigned NIL = 32'hffff_ffff;
    localparam int SEGS = DEF_MAX_SEGMENTS;
    localparam int EDGES = DEF_MAX_EDGES;
    localparam int POOL = DEF_MAX_SEGMENTS + DEF_MAX_EDGES;

    logic [CFG_W-1:0]  seg_count;
    logic [LEN_W-1:0]  seg_len[SEGS];
    logic [LEN_W-1:0]  max_len;
    int unsigned       edge_first[SEGS];
    int unsigned       edge_last[SEGS];
    logic [IDX_W-1:0]  edge_to[EDGES];
    int unsigned       edge_cnt;
    bit                is_origin[SEGS];
    logic [DIST_W-1:0] seen_at[SEGS];
    logic [DIST_W-1:0] walk_dist[SEGS];
    logic [DIST_W-1:0] out_dist[SEGS];
    bit                finished[SEGS];
    bit                got_dist[SEGS];
    int unsigned       bkt_head[NUM_BUCKETS];
    logic [IDX_W-1:0]  node_seg[POOL];
    int unsigned       node_next[POOL];
    int unsigned       free_node;
    int unsigned       open_cnt;
    logic [DIST_W-1:0] advances;
    int unsigned       cur_bkt;
    path_result_t      pending_results[$];
    int                mismatches;
    int                checked;

    function new();
        seg_count = 0;
        max_len = 0;
        edge_cnt = 0;
        mismatches = 0;
        checked = 0;
        for (int i = 0; i < SEGS; i++)
        begin
            seg_len[i] = 0;
            edge_first[i] = 0;
            edge_last[i] = 0;
            is_origin[i] = 0;
            seen_at[i] = '1;
            walk_dist[i] = 0;
            out_dist[i] = 0;
            finished[i] = 0;
            got_dist[i] = 0;
        end
    endfunction

    function int unsigned active();
        return (seg_count > SEGS) ? SEGS : seg_count;
    endfunction

    function logic [DIST_W-1:0] add_sat(logic [DIST_W-1:0] a, logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? '1 : s[DIST_W-1:0];
    endfunction

    function logic [DIST_W-1:0] half(logic [LEN_W-1:0] l);
        return ({8'd0, l} + 32'd1) >> 1;
    endfunction

    function int unsigned step_of(logic [LEN_W-1:0] l);
        longint unsigned q;
        if (max_len == 0)
            return 0;
        q = (64'd1022 * l + max_len) / (64'd2 * max_len);
        return 32'(q % NUM_BUCKETS);
    endfunction

    function bit enqueue(int unsigned b, int unsigned seg);
        int unsigned e;
        e = free_node;
        if (e == NIL)
            return 0;
        free_node = node_next[e];
        node_seg[e] = seg[IDX_W-1:0];
        node_next[e] = bkt_head[b];
        bkt_head[b] = e;
        open_cnt++;
        return 1;
    endfunction

    function int unsigned dequeue(int unsigned b);
        int unsigned e;
        e = bkt_head[b];
        bkt_head[b] = node_next[e];
        node_next[e] = free_node;
        free_node = e;
        open_cnt--;
        return node_seg[e];
    endfunction

    function bit walk();
        int unsigned n;
        int unsigned seg;
        int unsigned stop;
        int unsigned t;
        bit ok;
        n = active();
        ok = 1;
        max_len = 0;
        for (int i = 0; i < n; i++)
        begin
            seen_at[i] = '1;
            finished[i] = 0;
            got_dist[i] = 0;
            if (seg_len[i] > max_len)
                max_len = seg_len[i];
        end
        for (int i = 0; i < NUM_BUCKETS; i++)
            bkt_head[i] = NIL;
        for (int i = 0; i < POOL; i++)
            node_next[i] = (i + 1 < POOL) ? i + 1 : NIL;
        free_node = 0;
        open_cnt = 0;
        advances = 0;
        cur_bkt = 0;
        for (int i = 0; i < n; i++)
        begin
            if (is_origin[i])
            begin
                seen_at[i] = 0;
                walk_dist[i] = half(seg_len[i]);
                out_dist[i] = 0;
                got_dist[i] = 1;
                if (!enqueue(step_of(seg_len[i]), i))
                    ok = 0;
            end
        end
        while (open_cnt != 0)
        begin
            while (bkt_head[cur_bkt] == NIL)
            begin
                cur_bkt = (cur_bkt + 1) % NUM_BUCKETS;
                advances++;
            end
            seg = dequeue(cur_bkt);
            if (seg >= SEGS || finished[seg])
                continue;
            finished[seg] = 1;
            stop = (edge_last[seg] > EDGES) ? EDGES : edge_last[seg];
            for (int unsigned e = edge_first[seg]; e < stop; e++)
            begin
                t = edge_to[e];
                if (t >= n || seen_at[t] <= advances)
                    continue;
                seen_at[t] = advances;
                walk_dist[t] = add_sat(walk_dist[seg], seg_len[t]);
                out_dist[t] = add_sat(walk_dist[seg], half(seg_len[t]));
                got_dist[t] = 1;
                if (!enqueue((cur_bkt + step_of(seg_len[t])) % NUM_BUCKETS, t))
                    ok = 0;
            end
        end
        return ok;
    endfunction

    function void set_count(logic [CFG_W-1:0] v);
        seg_count = v;
    endfunction

    function void note_input(logic [CMD_W-1:0] c, logic [IDX_W-1:0] s,
                             logic [IDX_W-1:0] t, logic [LEN_W-1:0] l);
        path_result_t r;
        int unsigned n;
        n = active();
        r = '{STAT_OK, 1'b0, 1'b0, '0};
        case (c)
            CMD_SET_LENGTH:
                if (s >= n) r.status = STAT_RANGE;
                else seg_len[s] = l;
            CMD_APPEND:
                if (s >= n || t >= n) r.status = STAT_RANGE;
                else if (edge_cnt >= EDGES) r.status = STAT_FULL;
                else
                begin
                    if (edge_first[s] == edge_last[s])
                        edge_first[s] = edge_cnt;
                    edge_to[edge_cnt] = t;
                    edge_cnt++;
                    edge_last[s] = edge_cnt;
                end
            CMD_MARK:
                if (s >= n) r.status = STAT_RANGE;
                else is_origin[s] = 1;
            CMD_RUN:
            begin
                if (!walk())
                    r.status = STAT_FULL;
                r.run_done = 1;
            end
            CMD_READ:
                if (s >= n) r.status = STAT_RANGE;
                else if (got_dist[s])
                begin
                    r.reached = 1;
                    r.distance = out_dist[s];
                end
            CMD_CLEAR:
            begin
                for (int i = 0; i < SEGS; i++)
                begin
                    edge_first[i] = 0;
                    edge_last[i] = 0;
                    is_origin[i] = 0;
                    got_dist[i] = 0;
                end
                edge_cnt = 0;
            end
            default: ;
        endcase
        pending_results.insert(pending_results.size(), r);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] d);
        path_result_t x;
        path_result_t a;
        a.status = d[1:0];
        a.run_done = d[2];
        a.reached = d[3];
        a.distance = d[35:4];
        checked++;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result transaction: status %0d done %0b reached %0b dist %h",
                         a.status, a.run_done, a.reached, a.distance);
            return;
        end
        x = pending_results.pop_front();
        if (x.status !== a.status || x.run_done !== a.run_done || x.reached !== a.reached
            || x.distance !== a.distance)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp status %0d done %0b reached %0b dist %h, got %0d %0b %0b %h",
                         x.status, x.run_done, x.reached, x.distance,
                         a.status, a.run_done, a.reached, a.distance);
        end
    endfunction

    function int outstanding();
        return pending_results.size();
    endfunction
endclass

module tb_bucket_queue_metric_shortest_path;

    localparam int CYCLE_LIMIT = 4000000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [CMD_W-1:0]     s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 cfg_we;
    logic [CFG_W-1:0]     cfg_wdata;

    path_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold;
    int cycles;
    int items_sent;
    int runs;

    bucket_queue_metric_shortest_path u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receive side: ready changes at the falling edge, results sampled at the rising edge
    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            m_axis_tready = 1'b0;
            recv_hold = recv_hold - 1;
        end
        else
            m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    task automatic put_cmd(logic [CMD_W-1:0] c, int unsigned s, int unsigned t,
                           int unsigned l);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = c;
        s_axis_tdata = {4'd0, l[LEN_W-1:0], t[IDX_W-1:0], s[IDX_W-1:0]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(c, s[IDX_W-1:0], t[IDX_W-1:0], l[LEN_W-1:0]);
        items_sent++;
        if (c == CMD_RUN)
            runs++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_count(int unsigned v);
        drain();
        cfg_we = 1'b1;
        cfg_wdata = v[CFG_W-1:0];
        sb.set_count(v[CFG_W-1:0]);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic int unsigned pick_len();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 24'hffffff;
            2: return $urandom_range(1, 255);
            default: return $urandom_range(0, 24'hffffff);
        endcase
    endfunction

    task automatic graph_round(int unsigned n, bit hold_out);
        int unsigned edges;
        int unsigned o;
        write_count(n);
        for (int i = 0; i < n; i++)
            put_cmd(CMD_SET_LENGTH, i, 0, pick_len());
        put_cmd(CMD_CLEAR, 0, 0, 0);
        edges = $urandom_range(n, 3 * n);
        for (int k = 0; k < edges; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                put_cmd(CMD_APPEND, $urandom_range(0, n + 1), $urandom_range(0, n + 1), 0);
            else
                put_cmd(CMD_APPEND, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                        $urandom);
        end
        o = $urandom_range(0, n - 1);
        put_cmd(CMD_MARK, o, 0, 0);
        if ($urandom_range(0, 1))
            put_cmd(CMD_MARK, $urandom_range(0, n - 1), 0, 0);
        put_cmd(CMD_MARK, o, 0, 0);
        if ($urandom_range(0, 3) == 0)
            put_cmd(CMD_W'($urandom_range(6, 7)), $urandom, $urandom, $urandom);
        // shrinking the count leaves edges that point past the end
        if (n > 2 && $urandom_range(0, 2) == 0)
        begin
            n = n - 1;
            write_count(n);
        end
        put_cmd(CMD_RUN, 0, 0, 0);
        if (hold_out)
            recv_hold = 400;
        for (int i = 0; i <= n; i++)
            put_cmd(CMD_READ, i, 0, 0);
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        items_sent = 0;
        runs = 0;
        recv_hold = 0;
        send_idle_pct = 32;
        recv_idle_pct = 73;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // count of zero: every index is out of range, run is empty
        write_count(0);
        put_cmd(CMD_SET_LENGTH, 0, 0, 5);
        put_cmd(CMD_RUN, 0, 0, 0);
        put_cmd(CMD_READ, 0, 0, 0);
        put_cmd(CMD_MARK, 0, 0, 0);
        put_cmd(3'd6, 0, 0, 0);
        put_cmd(3'd7, 10'h3ff, 10'h3ff, 24'hffffff);

        // full count, top indexes
        write_count(1024);
        put_cmd(CMD_SET_LENGTH, 1023, 0, 24'hffffff);
        put_cmd(CMD_SET_LENGTH, 0, 0, 0);
        put_cmd(CMD_APPEND, 1023, 1023, 0);
        put_cmd(CMD_APPEND, 0, 1023, 0);
        put_cmd(CMD_READ, 1023, 0, 0);
        put_cmd(CMD_MARK, 1023, 0, 0);
        put_cmd(CMD_CLEAR, 0, 0, 0);

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                send_idle_pct = 73;
                recv_idle_pct = 32;
            end
            else if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            graph_round($urandom_range(2, 5), ph == 1 || ph == 5);
        end

        drain();
        repeat (100) @(negedge clk);
        $display("sent %0d commands over %0d walks: range errors, top indexes, stale edges,",
                 items_sent, runs);
        $display("repeated origins, unknown commands, output stalls; %0d results checked",
                 sb.checked);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/bqsp_pkg.sv
hw/rtl/bqsp_step_div.sv
hw/rtl/bqsp_datapath.sv
hw/rtl/bqsp_ctrl.sv
hw/rtl/bucket_queue_metric_shortest_path.sv
tb/tb_bucket_queue_metric_shortest_path.sv
